// File: sv/hdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_pkg: shared types and constants of the hashed key dedup filter
// Hash constants, table geometry, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hdf_pkg;

  // table geometry, entry count is a power of two
  localparam int unsigned TABLE_ENTRIES = 32768;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);

  // field widths
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;

  // fnv-1a constants
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  // probe limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd48;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd1;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } hdf_state_e;

  // controller to datapath
  typedef struct packed {
    logic hash_step;   // fold a non-final byte
    logic key_load;    // fold the final byte, latch key and start slot
    logic clr_wr;      // write zero at the current slot (clearing pass)
    logic key_wr;      // insert the key at the current slot
    logic slot_inc;    // advance the slot with wraparound
    logic cnt_inc;     // count one more examined slot
    logic out_load;    // load the result register
    logic out_new;     // result is a new key
    logic out_exh;     // result is an exhausted probe
  } hdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_last;   // slot pointer at the final table entry
    logic hit;         // read entry equals the key
    logic empty;       // read entry is free
    logic at_limit;    // this check uses the last allowed probe
    logic out_full;    // result register still holds a request
  } hdf_sts_t;

endpackage

// File: sv/hdf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_if: channel interfaces of the hashed key dedup filter
// Key byte channel, result channel and probe limit write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface hdf_key_if;
  import hdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] key_byte;
  logic              last_byte;
  modport source (output valid, key_byte, last_byte, input ready);
  modport sink   (input valid, key_byte, last_byte, output ready);
endinterface

interface hdf_res_if;
  import hdf_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_new;
  logic [HASH_W-1:0] key_hash;
  logic              probe_exhausted;
  modport source (output valid, is_new, key_hash, probe_exhausted, input ready);
  modport sink   (input valid, is_new, key_hash, probe_exhausted, output ready);
endinterface

interface hdf_cfg_if;
  import hdf_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/hdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_ctrl: controller of the hashed key dedup filter
// Sequences the clearing pass, byte intake and the linear probe walk, and
// drives the datapath by command signals.
// ----------------------------------------------------------------------------
module hdf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  hdf_pkg::hdf_sts_t sts_i,
  output hdf_pkg::hdf_cmd_t cmd_o
);
  import hdf_pkg::*;

  hdf_state_e state_q, state_d;
  logic       in_fire;

  // a final byte waits while the result register is occupied
  assign in_ready_o = (state_q == ST_IDLE) && !(in_last_i && sts_i.out_full);
  assign in_fire    = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.slot_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && in_last_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.hit || sts_i.empty || sts_i.at_limit) state_d = ST_IDLE;
        else state_d = ST_READ;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.slot_inc = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.hash_step = in_fire && !in_last_i;
        cmd_o.key_load  = in_fire && in_last_i;
      end
      ST_READ: begin
        cmd_o = '0;
      end
      ST_CHECK: begin
        if (sts_i.hit) begin
          cmd_o.out_load = 1'b1;
        end else if (sts_i.empty) begin
          cmd_o.key_wr   = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_new  = 1'b1;
        end else if (sts_i.at_limit) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_exh  = 1'b1;
        end else begin
          cmd_o.slot_inc = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: sv/hdf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_datapath: datapath of the hashed key dedup filter
// Running fnv-1a hash, seen table memory, slot pointer, probe counter,
// probe limit register and the result register.
// ----------------------------------------------------------------------------
module hdf_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hdf_pkg::hdf_cmd_t          cmd_i,
  output hdf_pkg::hdf_sts_t          sts_o,
  input  logic [hdf_pkg::BYTE_W-1:0] key_byte_i,
  input  logic                       cfg_valid_i,
  input  logic [hdf_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       is_new_o,
  output logic [hdf_pkg::HASH_W-1:0] key_hash_o,
  output logic                       exhausted_o
);
  import hdf_pkg::*;

  logic [HASH_W-1:0]  run_hash_q;
  logic [HASH_W-1:0]  key_q;
  logic [HASH_W-1:0]  prod;
  logic [HASH_W-1:0]  key_fixed;
  logic [ADDR_W-1:0]  slot_q;
  logic [LIMIT_W-1:0] cnt_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] limit_eff;
  logic [HASH_W-1:0]  mem [TABLE_ENTRIES];
  logic [HASH_W-1:0]  rd_q;
  logic               mem_we;
  logic [HASH_W-1:0]  mem_wd;
  logic               out_valid_q;
  logic               out_new_q;
  logic               out_exh_q;
  logic [HASH_W-1:0]  out_hash_q;

  // fnv-1a fold, low word of the product
  assign prod      = HASH_W'((run_hash_q ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte_i}) * FNV_PRIME);
  // zero marks a free entry, so a zero hash becomes one
  assign key_fixed = (prod == '0) ? HASH_W'(1) : prod;

  // running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_hash_q <= FNV_BASIS;
    end else if (cmd_i.key_load) begin
      run_hash_q <= FNV_BASIS;
    end else if (cmd_i.hash_step) begin
      run_hash_q <= prod;
    end
  end

  // finished key
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) key_q <= key_fixed;
  end

  // slot pointer, also the clearing address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (cmd_i.key_load) begin
      slot_q <= key_fixed[ADDR_W-1:0];
    end else if (cmd_i.slot_inc) begin
      slot_q <= sts_o.slot_last ? '0 : slot_q + ADDR_W'(1);
    end
  end

  // probe counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.key_load) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + LIMIT_W'(1);
    end
  end

  // probe limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // zero counts as one, large values saturate
  always_comb begin
    if (limit_q == '0)           limit_eff = LIMIT_MIN;
    else if (limit_q > LIMIT_MAX) limit_eff = LIMIT_MAX;
    else                          limit_eff = limit_q;
  end

  // seen table, one port, registered read
  assign mem_we = cmd_i.clr_wr || cmd_i.key_wr;
  assign mem_wd = cmd_i.key_wr ? key_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[slot_q] <= mem_wd;
    rd_q <= mem[slot_q];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_new_q  <= cmd_i.out_new;
      out_exh_q  <= cmd_i.out_exh;
      out_hash_q <= key_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_new_o    = out_new_q;
  assign exhausted_o = out_exh_q;
  assign key_hash_o  = out_hash_q;

  // status towards the controller
  assign sts_o.slot_last = (slot_q == ADDR_W'(TABLE_ENTRIES - 1));
  assign sts_o.hit       = (rd_q == key_q);
  assign sts_o.empty     = (rd_q == '0);
  assign sts_o.at_limit  = ((cnt_q + LIMIT_W'(1)) == limit_eff);
  assign sts_o.out_full  = out_valid_q;

endmodule

// File: sv/hashed_key_dedup_filter_unit.sv
`timescale 1ns / 1ps
// Probe: a final byte latches the key and its home slot; each examined slot, n of
//   them (1 to 64), passes through ST_READ and then ST_CHECK, the last check loading the result.
// Throughput: one byte per cycle while hashing, a final byte waiting while the
//   result register is occupied; one key at a time while probing.
// Reset: after rst_ni all 32768 entries of the seen table are swept to zero with
//   key_i.ready low; probe limit writes are taken throughout.
// ----------------------------------------------------------------------------
// hashed_key_dedup_filter_unit: fnv-1a key hash with linear probing set
// Hashes key bytes and reports whether each finished key is new, inserting
// it into the seen table when a free slot is found within the probe limit.
// ----------------------------------------------------------------------------
module hashed_key_dedup_filter_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  hdf_key_if.sink   key_i,
  hdf_res_if.source res_o,
  hdf_cfg_if.sink   cfg_i
);
  import hdf_pkg::*;

  hdf_cmd_t cmd;
  hdf_sts_t sts;
  logic     in_ready;

  assign key_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  // controller
  hdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (key_i.valid),
    .in_last_i  (key_i.last_byte),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  hdf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_byte_i  (key_i.key_byte),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .is_new_o    (res_o.is_new),
    .key_hash_o  (res_o.key_hash),
    .exhausted_o (res_o.probe_exhausted)
  );

  // a result only appears after the controller loaded one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // a new key never overwrites a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.key_load |-> !sts.out_full)
    else $error("key finished while result register full");

  // insertion only into a free slot and always reported as new
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.key_wr |-> (sts.empty && cmd.out_load && cmd.out_new))
    else $error("insert into an occupied slot");

  // a stored key is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.key_hash != '0))
    else $error("zero key hash reported");

endmodule

// File: dv/hdf_dedup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_dedup_checker: result checker of the hashed key dedup filter
// Watches the key, result and probe limit channels. It keeps its own running
// hash, its own copy of the seen table and the probe limit, and predicts the
// answer for every finished key. Each result request is compared field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hdf_dedup_checker (
  input  logic clk_i,
  input  logic rst_ni,
  hdf_key_if   key_i,
  hdf_res_if   res_i,
  hdf_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  import hdf_pkg::*;

  typedef struct packed {
    logic              is_new;
    logic [HASH_W-1:0] key_hash;
    logic              probe_exhausted;
  } verdict_t;

  logic [HASH_W-1:0]  shadow_table [TABLE_ENTRIES];
  logic [HASH_W-1:0]  hash_acc;
  logic [LIMIT_W-1:0] limit_reg;
  verdict_t           verdict_q [$];
  int                 fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = verdict_q.size();

  // zero means at least one slot, and no walk is longer than the cap or the table
  function automatic int unsigned slots_allowed(input logic [LIMIT_W-1:0] raw);
    int unsigned n;
    n = (raw == '0) ? 32'(LIMIT_MIN) : 32'(raw);
    if (n > LIMIT_MAX) n = LIMIT_MAX;
    if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
    return n;
  endfunction

  // linear probe from the home slot, inserting on the first free entry
  function automatic verdict_t probe_and_insert(input logic [HASH_W-1:0] h);
    verdict_t    v;
    int unsigned slot;
    int unsigned budget;
    slot              = h % TABLE_ENTRIES;
    budget            = slots_allowed(limit_reg);
    v.key_hash        = h;
    v.is_new          = 1'b0;
    v.probe_exhausted = 1'b1;
    for (int unsigned n = 0; n < budget; n++) begin
      if (shadow_table[slot] == h) begin
        v.probe_exhausted = 1'b0;
        return v;
      end
      if (shadow_table[slot] == '0) begin
        shadow_table[slot] = h;
        v.is_new           = 1'b1;
        v.probe_exhausted  = 1'b0;
        return v;
      end
      slot = (slot + 1 == TABLE_ENTRIES) ? 0 : slot + 1;
    end
    return v;
  endfunction

  // model update and comparison on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    logic [HASH_W-1:0] h;
    verdict_t          want;
    if (!rst_ni) begin
      foreach (shadow_table[i]) shadow_table[i] = '0;
      hash_acc  = FNV_BASIS;
      limit_reg = LIMIT_RESET;
      verdict_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) limit_reg = cfg_i.data;

      if (key_i.valid && key_i.ready) begin
        hash_acc = (hash_acc ^ {{(HASH_W-BYTE_W){1'b0}}, key_i.key_byte}) * FNV_PRIME;
        if (key_i.last_byte) begin
          h        = (hash_acc == '0) ? HASH_W'(1) : hash_acc;
          hash_acc = FNV_BASIS;
          verdict_q.push_back(probe_and_insert(h));
        end
      end

      if (res_i.valid && res_i.ready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual new=%0d hash=%h exh=%0d",
                   $time, res_i.is_new, res_i.key_hash, res_i.probe_exhausted);
        end else begin
          want = verdict_q.pop_front();
          if (res_i.key_hash !== want.key_hash) begin
            fail_count++;
            $display("%0t: key_hash mismatch, expected %h actual %h",
                     $time, want.key_hash, res_i.key_hash);
          end
          if (res_i.is_new !== want.is_new) begin
            fail_count++;
            $display("%0t: is_new mismatch for hash %h, expected %0d actual %0d",
                     $time, want.key_hash, want.is_new, res_i.is_new);
          end
          if (res_i.probe_exhausted !== want.probe_exhausted) begin
            fail_count++;
            $display("%0t: probe_exhausted mismatch for hash %h, expected %0d actual %0d",
                     $time, want.key_hash, want.probe_exhausted, res_i.probe_exhausted);
          end
        end
      end
    end
  end

endmodule

// File: dv/hashed_key_dedup_filter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_dedup_filter_unit_test: testbench of the hashed key dedup filter
// Sends keys byte by byte: byte extremes, a key whose hash folds to zero,
// repeated keys, and keys built to land on chosen table slots so that probe
// chains grow, wrap past the last slot and run out. The probe limit is moved
// through its extremes between phases. Both channels idle at random. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module hashed_key_dedup_filter_unit_test;
  import hdf_pkg::*;

  localparam int SETTLE_CYCLES = 2 * LIMIT_MAX + 12;
  localparam int BYTE_TARGET   = 1250;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;

  hdf_key_if key_bus ();
  hdf_res_if res_bus ();
  hdf_cfg_if cfg_bus ();

  bit                gaps_on = 1'b0;
  int                sent_bytes = 0;
  logic [HASH_W-1:0] prime_inv;
  int unsigned       chain_base [8];
  logic [63:0]       hist_keys [$];
  int                hist_lens [$];

  hashed_key_dedup_filter_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  hdf_dedup_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_bus),
    .res_i        (res_bus),
    .cfg_i        (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    if ($urandom_range(99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    return (h ^ {{(HASH_W-BYTE_W){1'b0}}, b}) * FNV_PRIME;
  endfunction

  // one key byte request, with an optional pause in front
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int pause;
    if (gaps_on && $urandom_range(99) < 30) begin
      pause = pick_pause();
      key_bus.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    key_bus.valid     <= 1'b1;
    key_bus.key_byte  <= b;
    key_bus.last_byte <= lst;
    do @(negedge clk_i); while (key_bus.ready !== 1'b1);
    @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_key(input logic [63:0] kb, input int kl);
    for (int i = 0; i < kl; i++) push_byte(kb[8*i +: 8], i == kl - 1);
    hist_keys.push_back(kb);
    hist_lens.push_back(kl);
  endtask

  // key whose hash lands on a chosen slot: random prefix, closing byte solved
  task automatic key_at_slot(input int unsigned slot, output logic [63:0] kb, output int kl);
    logic [HASH_W-1:0] mix;
    logic [HASH_W-1:0] acc;
    mix = slot * prime_inv;
    do begin
      kl  = $urandom_range(1, 3);
      kb  = {$urandom, $urandom};
      acc = FNV_BASIS;
      for (int i = 0; i < kl; i++) acc = fnv_fold(acc, kb[8*i +: 8]);
    end while (acc[ADDR_W-1:BYTE_W] != mix[ADDR_W-1:BYTE_W]);
    kb[8*kl +: 8] = acc[7:0] ^ mix[7:0];
    kl++;
  endtask

  // five byte key whose hash is zero: the fourth byte steers the running hash
  // to a value below 256, the fifth byte cancels it
  task automatic find_zero_key(output logic [63:0] kb);
    int unsigned       by_top [bit [23:0]];
    logic [HASH_W-1:0] mix;
    logic [HASH_W-1:0] acc;
    int unsigned       p;
    bit                found;
    for (int unsigned c = 0; c < 256; c++) begin
      mix = c * prime_inv;
      by_top[mix[31:8]] = c;
    end
    found = 1'b0;
    p     = 0;
    kb    = '0;
    while (!found && p < (1 << 24)) begin
      acc = fnv_fold(fnv_fold(fnv_fold(FNV_BASIS, p[23:16]), p[15:8]), p[7:0]);
      if (by_top.exists(acc[31:8])) begin
        mix        = by_top[acc[31:8]] * prime_inv;
        kb[23:0]   = {p[7:0], p[15:8], p[23:16]};
        kb[31:24]  = acc[7:0] ^ mix[7:0];
        kb[39:32]  = 8'(by_top[acc[31:8]]);
        found      = 1'b1;
      end
      p++;
    end
  endtask

  task automatic random_key(output logic [63:0] kb, output int kl);
    kl = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
    kb = {$urandom, $urandom};
  endtask

  // drain all results, then let the last probe walk finish
  task automatic finish_phase();
    key_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(negedge clk_i); while (cfg_bus.ready !== 1'b1);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        hold--;
      end else if (gaps_on && $urandom_range(99) < 25) begin
        res_bus.ready <= 1'b0;
        hold = pick_pause() - 1;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [63:0]        kb;
    logic [63:0]        zero_key;
    logic [63:0]        kb_a;
    int                 kl;
    int                 kl_a;
    int                 phase;
    int                 n_keys;
    int                 pick;
    int unsigned        slot;
    logic [LIMIT_W-1:0] lim;

    rst_ni            <= 1'b0;
    key_bus.valid     <= 1'b0;
    key_bus.key_byte  <= '0;
    key_bus.last_byte <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.data      <= '0;

    // inverse of the prime, newton iteration doubles the good bits each round
    prime_inv = FNV_PRIME;
    repeat (5) prime_inv = prime_inv * (32'd2 - FNV_PRIME * prime_inv);
    find_zero_key(zero_key);
    foreach (chain_base[i]) chain_base[i] = $urandom_range(0, TABLE_ENTRIES - 1);
    chain_base[1] = TABLE_ENTRIES - 2;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // limit write lands during the clearing sweep
    write_limit(LIMIT_RESET);

    // byte extremes, a repeat, the zero hash key twice
    send_key(64'h00, 1);
    send_key(64'hff, 1);
    send_key(64'h00, 1);
    send_key(zero_key, 5);
    send_key(zero_key, 5);

    // home slot on the last entry, probing wraps to slot zero
    repeat (3) begin
      key_at_slot(TABLE_ENTRIES - 1, kb, kl);
      send_key(kb, kl);
    end
    finish_phase();

    // limit zero acts as one: first key in, next two run out, first seen again
    write_limit('0);
    key_at_slot(chain_base[2], kb_a, kl_a);
    send_key(kb_a, kl_a);
    repeat (2) begin
      key_at_slot(chain_base[2], kb, kl);
      send_key(kb, kl);
    end
    send_key(kb_a, kl_a);

    // random phases; the first builds one chain past the longest walk
    phase = 0;
    while (sent_bytes < BYTE_TARGET) begin
      finish_phase();
      case ($urandom_range(9))
        0:       lim = '0;
        1:       lim = LIMIT_MIN;
        2:       lim = LIMIT_W'(2);
        3:       lim = LIMIT_MAX;
        4:       lim = LIMIT_MAX + LIMIT_W'(1);
        5:       lim = '1;
        6:       lim = LIMIT_RESET;
        default: lim = LIMIT_W'($urandom_range(0, 127));
      endcase
      if (phase == 0) lim = '1;
      write_limit(lim);
      gaps_on = (phase == 0) ? 1'b0 : ($urandom_range(3) != 0);
      n_keys  = (phase == 0) ? 72 : $urandom_range(10, 30);
      repeat (n_keys) begin
        pick = (phase == 0) ? 0 : $urandom_range(99);
        if (pick < 50) begin
          slot = (phase == 0) ? chain_base[0]
                              : (chain_base[$urandom_range(0, 7)] + $urandom_range(0, 3))
                                % TABLE_ENTRIES;
          key_at_slot(slot, kb, kl);
        end else if (pick < 70) begin
          pick = $urandom_range(0, hist_keys.size() - 1);
          kb   = hist_keys[pick];
          kl   = hist_lens[pick];
        end else begin
          random_key(kb, kl);
        end
        send_key(kb, kl);
      end
      phase++;
    end
    finish_phase();

    if (pending != 0)
      $display("%0t: results missing, expected %0d more, actual none", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
sv/hdf_pkg.sv
sv/hdf_if.sv
sv/hdf_ctrl.sv
sv/hdf_datapath.sv
sv/hashed_key_dedup_filter_unit.sv
dv/hdf_dedup_checker.sv
dv/hashed_key_dedup_filter_unit_test.sv
